// ===== rtl/core/csec_pkg.sv =====
// Shared types, codes and helpers for the clock set/encoder controller.
// No dependencies; compiled first.
package csec_pkg;

    localparam int FUNC_W   = 3;
    localparam int RTC_H_W  = 5;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 4;
    localparam int MODE_W   = 2;
    localparam int DIGIT_W  = 10;
    localparam int SLEEP_W  = 8;
    localparam int TOGGLE_W = 4;
    localparam int CFG_DATA_W = 8;

    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [HOUR_W-1:0]  t_hour;
    typedef logic [MIN_W-1:0]   t_min;
    typedef logic [DIGIT_W-1:0] t_digits;

    localparam t_mode MODE_OFF  = 2'd0;
    localparam t_mode MODE_VIEW = 2'd1;
    localparam t_mode MODE_SETH = 2'd2;
    localparam t_mode MODE_SETM = 2'd3;

    localparam t_func FUNC_TICK   = 3'd0;
    localparam t_func FUNC_BUTTON = 3'd1;
    localparam t_func FUNC_ENC_A  = 3'd2;
    localparam t_func FUNC_ENC_B  = 3'd3;

    localparam logic CFG_SLEEP_TIMEOUT = 1'b0;
    localparam logic CFG_TOGGLE_PERIOD = 1'b1;

    localparam logic [SLEEP_W-1:0]  SLEEP_TIMEOUT_RST = 8'd20;
    localparam logic [TOGGLE_W-1:0] TOGGLE_PERIOD_RST = 4'd2;
    localparam logic [SLEEP_W-1:0]  SLEEP_MAX         = 8'd255;
    localparam t_hour HOURS_MAX   = 4'd12;
    localparam t_min  MINUTES_MAX = 6'd59;

    // tens digit of a value below 60
    function automatic logic [2:0] tens_of(input t_min v);
        logic [2:0] t;
        if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    function automatic t_digits tens_onehot(input t_min v);
        t_digits d;
        d = '0;
        d[{1'b0, tens_of(v)}] = 1'b1;
        return d;
    endfunction

    function automatic t_digits ones_onehot(input t_min v);
        logic [MIN_W-1:0] r;
        t_digits d;
        r = v - (t_min'(tens_of(v)) * t_min'(10));
        d = '0;
        d[r[3:0]] = 1'b1;
        return d;
    endfunction

endpackage

// ===== rtl/core/csec_in_if.sv =====
// Event request channel of the clock set/encoder controller.
// Depends on csec_pkg.
interface csec_in_if
    import csec_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic                 pin_level;
    logic [RTC_H_W-1:0]   rtc_hours;
    logic [MIN_W-1:0]     rtc_minutes;

    modport source (output valid, func, pin_level, rtc_hours, rtc_minutes, input ready);
    modport sink   (input valid, func, pin_level, rtc_hours, rtc_minutes, output ready);
endinterface

// ===== rtl/core/csec_out_if.sv =====
// Result request channel of the clock set/encoder controller.
// Depends on csec_pkg.
interface csec_out_if
    import csec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] tens_onehot;
    logic [DIGIT_W-1:0] ones_onehot;
    logic               neon_hours;
    logic               neon_minutes;
    logic               hv_enable;
    logic               sleep_request;
    logic               time_write;
    logic [HOUR_W-1:0]  write_hours;
    logic [MIN_W-1:0]   write_minutes;
    logic [MODE_W-1:0]  mode_now;

    modport source (output valid, tens_onehot, ones_onehot, neon_hours, neon_minutes,
                    hv_enable, sleep_request, time_write, write_hours, write_minutes,
                    mode_now, input ready);
    modport sink   (input valid, tens_onehot, ones_onehot, neon_hours, neon_minutes,
                    hv_enable, sleep_request, time_write, write_hours, write_minutes,
                    mode_now, output ready);
endinterface

// ===== rtl/core/clock_set_encoder_controller.sv =====
// Top level of the clock set/encoder controller: mode, time, encoder and timers.
// Depends on csec_pkg, csec_in_if and csec_out_if.
//
//   channel   dir  handshake          payload
//   i_evt     in   valid/ready        func, pin_level, rtc_hours, rtc_minutes
//   o_res     out  valid/ready        digit drive, lamps, hv, sleep, RTC write, mode
//   i_cfg_*   in   write enable only  addr 0 sleep_timeout, addr 1 toggle_period
//
// One request per cycle when ready; a result is registered, valid the next cycle.
// State update and result decode are one combinational pass from the state registers.
// i_evt is ready whenever the result register is empty or being drained.
// Synchronous active-low reset; no clearing pass.
module clock_set_encoder_controller
    import csec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csec_in_if.sink               i_evt,
    csec_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] ENC_DN0 = 4'b0110;
    localparam logic [3:0] ENC_DN1 = 4'b1001;
    localparam logic [3:0] ENC_UP0 = 4'b1100;
    localparam logic [3:0] ENC_UP1 = 4'b0011;

    logic [SLEEP_W-1:0]  r_sleep_timeout;
    logic [TOGGLE_W-1:0] r_toggle_period;

    t_mode               r_mode, n_mode;
    logic                r_show_hours, n_show_hours;
    t_hour               r_hour, n_hour;
    t_min                r_min, n_min;
    logic [SLEEP_W-1:0]  r_sleep, n_sleep;
    logic [TOGGLE_W-1:0] r_tog, n_tog;
    logic                r_a_now, n_a_now;
    logic                r_b_now, n_b_now;
    logic                r_a_last, n_a_last;
    logic                r_b_last, n_b_last;
    logic                r_hv, n_hv;

    logic                n_sleep_req, n_twrite;
    t_hour               n_wh;
    t_min                n_wm;
    t_min                disp_val;
    logic [3:0]          enc_pat;
    logic                step_up, step_dn;

    logic                r_out_valid;
    t_digits             r_tens, r_ones;
    logic                r_neon_h, r_hv_out, r_sleep_out, r_twrite_out;
    t_hour               r_wh;
    t_min                r_wm;
    t_mode               r_mode_out;

    logic                accept;

    assign i_evt.ready = !r_out_valid || o_res.ready;
    assign accept      = i_evt.valid && i_evt.ready;

    assign enc_pat = {i_evt.pin_level, r_b_now, r_a_last, r_b_last};
    assign step_dn = (enc_pat == ENC_DN0) || (enc_pat == ENC_DN1);
    assign step_up = (enc_pat == ENC_UP0) || (enc_pat == ENC_UP1);

    always_comb begin
        n_mode       = r_mode;
        n_show_hours = r_show_hours;
        n_hour       = r_hour;
        n_min        = r_min;
        n_sleep      = r_sleep;
        n_tog        = r_tog;
        n_a_now      = r_a_now;
        n_b_now      = r_b_now;
        n_a_last     = r_a_last;
        n_b_last     = r_b_last;
        n_hv         = r_hv;
        n_sleep_req  = 1'b0;
        n_twrite     = 1'b0;
        n_wh         = '0;
        n_wm         = '0;

        if (i_evt.func == FUNC_TICK) begin
            n_min = (i_evt.rtc_minutes > MINUTES_MAX) ? MINUTES_MAX : i_evt.rtc_minutes;
            if (i_evt.rtc_hours > RTC_H_W'(HOURS_MAX)) begin
                n_hour   = '0;
                n_twrite = 1'b1;
                n_wm     = n_min;
            end else begin
                n_hour = i_evt.rtc_hours[HOUR_W-1:0];
            end
            if (r_mode == MODE_VIEW) begin
                n_sleep = (r_sleep != SLEEP_MAX) ? r_sleep + 1'b1 : r_sleep;
                n_tog   = r_tog + 1'b1;
                if (n_tog >= r_toggle_period) begin
                    n_show_hours = !r_show_hours;
                    n_tog        = '0;
                end
                if (n_sleep >= r_sleep_timeout) begin
                    n_sleep_req = 1'b1;
                    n_hv        = 1'b0;
                    n_mode      = MODE_OFF;
                    n_sleep     = '0;
                end
            end else begin
                n_sleep = '0;
            end
        end else begin
            if (i_evt.func == FUNC_BUTTON) begin
                n_mode = r_mode + 1'b1;
            end
            unique case (n_mode)
                MODE_VIEW: begin
                    n_hv = 1'b1;
                end
                MODE_SETH: begin
                    n_hv         = 1'b1;
                    n_show_hours = 1'b1;
                end
                MODE_SETM: begin
                    n_hv         = 1'b1;
                    n_show_hours = 1'b0;
                end
                default: begin
                    n_hv        = 1'b0;
                    n_sleep_req = 1'b1;
                end
            endcase
            if (i_evt.func == FUNC_ENC_A && (n_mode == MODE_SETH || n_mode == MODE_SETM)) begin
                n_a_now = i_evt.pin_level;
                if (n_mode == MODE_SETH) begin
                    if (step_dn) begin
                        n_hour = (r_hour <= 4'd1) ? HOURS_MAX : r_hour - 1'b1;
                    end else if (step_up) begin
                        n_hour = (r_hour >= HOURS_MAX) ? 4'd1 : r_hour + 1'b1;
                    end
                end else begin
                    if (step_dn) begin
                        n_min = (r_min == '0) ? MINUTES_MAX : r_min - 1'b1;
                    end else if (step_up) begin
                        n_min = (r_min >= MINUTES_MAX) ? '0 : r_min + 1'b1;
                    end
                end
                n_a_last = i_evt.pin_level;
                n_b_last = r_b_now;
                n_twrite = 1'b1;
                n_wh     = n_hour;
                n_wm     = n_min;
            end
            if (i_evt.func == FUNC_ENC_B) begin
                n_b_now = i_evt.pin_level;
            end
        end
    end

    assign disp_val = n_show_hours ? MIN_W'(n_hour) : n_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_timeout <= SLEEP_TIMEOUT_RST;
            r_toggle_period <= TOGGLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SLEEP_TIMEOUT: r_sleep_timeout <= i_cfg_data;
                CFG_TOGGLE_PERIOD: r_toggle_period <= i_cfg_data[TOGGLE_W-1:0];
                default:           r_sleep_timeout <= r_sleep_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_OFF;
            r_show_hours <= 1'b0;
            r_hour       <= HOURS_MAX;
            r_min        <= '0;
            r_sleep      <= '0;
            r_tog        <= '0;
            r_a_now      <= 1'b0;
            r_b_now      <= 1'b0;
            r_a_last     <= 1'b0;
            r_b_last     <= 1'b0;
            r_hv         <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_show_hours <= n_show_hours;
            r_hour       <= n_hour;
            r_min        <= n_min;
            r_sleep      <= n_sleep;
            r_tog        <= n_tog;
            r_a_now      <= n_a_now;
            r_b_now      <= n_b_now;
            r_a_last     <= n_a_last;
            r_b_last     <= n_b_last;
            r_hv         <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tens       <= tens_onehot(disp_val);
            r_ones       <= ones_onehot(disp_val);
            r_neon_h     <= n_show_hours;
            r_hv_out     <= n_hv;
            r_sleep_out  <= n_sleep_req;
            r_twrite_out <= n_twrite;
            r_wh         <= n_wh;
            r_wm         <= n_wm;
            r_mode_out   <= n_mode;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.tens_onehot   = r_tens;
    assign o_res.ones_onehot   = r_ones;
    assign o_res.neon_hours    = r_neon_h;
    assign o_res.neon_minutes  = !r_neon_h;
    assign o_res.hv_enable     = r_hv_out;
    assign o_res.sleep_request = r_sleep_out;
    assign o_res.time_write    = r_twrite_out;
    assign o_res.write_hours   = r_wh;
    assign o_res.write_minutes = r_wm;
    assign o_res.mode_now      = r_mode_out;

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour <= HOURS_MAX && r_min <= MINUTES_MAX)
        else $error("time state out of range");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.time_write |-> o_res.write_hours == '0 && o_res.write_minutes == '0)
        else $error("write fields set without time_write");

    a_sleep_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.sleep_request |-> o_res.mode_now == MODE_OFF && !o_res.hv_enable)
        else $error("sleep request while display active");

    a_digits_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> $onehot(o_res.tens_onehot) && $onehot(o_res.ones_onehot))
        else $error("digit drive not one-hot");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid && r_mode_out == r_mode)
        else $error("result register out of step with state");

endmodule
